// ===== design/timeout_table_manager_defines.svh =====
// assertion macros for the timeout table manager
// used by the top level only, no other dependencies
`ifndef TIMEOUT_TABLE_MANAGER_DEFINES_SVH
`define TIMEOUT_TABLE_MANAGER_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define TTM_ASSERT_NOW(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

`define TTM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define TTM_ASSERT_NOW(lbl, clk, rst, prop, msg)

`define TTM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

// ===== design/ttm_pkg.sv =====
// shared types and constants of the timeout table manager
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ttm_pkg;

   localparam int NUM_SLOTS  = 16;
   localparam int SLOT_W     = 4;
   localparam int TIME_W     = 48;
   localparam int MAX_FIRE   = 16;
   localparam int FIRE_CNT_W = $clog2(MAX_FIRE + 1);

   typedef enum logic [1:0] {
      REQ_SET     = 2'd0,
      REQ_REMOVE  = 2'd1,
      REQ_ADVANCE = 2'd2,
      REQ_COLLECT = 2'd3
   } ttm_req_code_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FIRE_SCAN,
      ST_EMIT_PLAIN,
      ST_EMIT_FIRE
   } ttm_state_type;

   typedef struct packed {
      logic apply;
      logic scan_start;
      logic fire;
      logic load_out;
      logic out_fired;
      logic out_last;
   } ttm_cmd_type;

   typedef struct packed {
      logic scan_busy;
      logic expired;
      logic is_collect;
      logic out_free;
   } ttm_stat_type;

endpackage

`default_nettype wire

// ===== design/timeout_table_manager.sv =====
// top level of the timeout table manager: controller plus datapath
// depends on ttm_pkg, ttm_ctrl, ttm_datapath and timeout_table_manager_defines.svh
`timescale 1ns / 1ps
`default_nettype none
`include "timeout_table_manager_defines.svh"

// Timer table of 16 slots with a 48-bit current time. One request is worked at a
// time: set, remove and advance each run one earliest-deadline scan, and a collect
// runs one scan plus one more for each slot that fires. The scan reads the deadline
// RAM through its single read port one slot per cycle. A new request is taken as
// soon as the last result beat is in the output register.

module timeout_table_manager (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic [1:0]                 req_type,
   input  wire logic [ttm_pkg::SLOT_W-1:0] req_slot_id,
   input  wire logic [ttm_pkg::TIME_W-1:0] req_time_value,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic                            rsp_fired_valid,
   output logic [ttm_pkg::SLOT_W-1:0]      rsp_fired_slot,
   output logic                            rsp_next_valid,
   output logic [ttm_pkg::TIME_W-1:0]      rsp_next_deadline,
   output logic                            rsp_time_error,
   output logic                            rsp_last
);

   import ttm_pkg::*;

   ttm_cmd_type  cmd;
   ttm_stat_type stat;

   ttm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   ttm_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_type          (req_type),
      .req_slot_id       (req_slot_id),
      .req_time_value    (req_time_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_fired_valid   (rsp_fired_valid),
      .rsp_fired_slot    (rsp_fired_slot),
      .rsp_next_valid    (rsp_next_valid),
      .rsp_next_deadline (rsp_next_deadline),
      .rsp_time_error    (rsp_time_error),
      .rsp_last          (rsp_last)
   );

   `TTM_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && !req_stall, req_stall, "request beat not followed by busy")
   `TTM_ASSERT_NOW(a_plain_is_last, clock, reset, !(rsp_valid && !rsp_fired_valid) || rsp_last, "non-fired beat not last")
   `TTM_ASSERT_NOW(a_no_next_zero, clock, reset, !(rsp_valid && !rsp_next_valid) || (rsp_next_deadline == '0), "empty table with nonzero deadline")
   `TTM_ASSERT_NOW(a_load_when_free, clock, reset, !cmd.load_out || !rsp_valid || !rsp_stall, "result loaded over a stalled beat")

endmodule

`default_nettype wire

// ===== design/ttm_ram.sv =====
// generic single write, single read ram with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module ttm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== design/ttm_ctrl.sv =====
// control state machine of the timeout table manager
// depends on ttm_pkg
`timescale 1ns / 1ps
`default_nettype none

module ttm_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire ttm_pkg::ttm_stat_type stat,
   output ttm_pkg::ttm_cmd_type      cmd
);

   import ttm_pkg::*;

   ttm_state_type state_ff;
   ttm_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (!stat.scan_busy) begin
               if (stat.is_collect && stat.expired) begin
                  state_in = ST_FIRE_SCAN;
               end else begin
                  state_in = ST_EMIT_PLAIN;
               end
            end
         end
         ST_FIRE_SCAN: begin
            if (!stat.scan_busy) begin
               state_in = ST_EMIT_FIRE;
            end
         end
         ST_EMIT_PLAIN: begin
            if (stat.out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT_FIRE: begin
            if (stat.out_free) begin
               state_in = stat.expired ? ST_FIRE_SCAN : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.apply      = 1'b1;
               cmd.scan_start = 1'b1;
            end
         end
         ST_SCAN: begin
            if (!stat.scan_busy && stat.is_collect && stat.expired) begin
               cmd.fire       = 1'b1;
               cmd.scan_start = 1'b1;
            end
         end
         ST_FIRE_SCAN: begin
         end
         ST_EMIT_PLAIN: begin
            if (stat.out_free) begin
               cmd.load_out = 1'b1;
               cmd.out_last = 1'b1;
            end
         end
         ST_EMIT_FIRE: begin
            if (stat.out_free) begin
               cmd.load_out  = 1'b1;
               cmd.out_fired = 1'b1;
               cmd.out_last  = !stat.expired;
               if (stat.expired) begin
                  cmd.fire       = 1'b1;
                  cmd.scan_start = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== design/ttm_datapath.sv =====
// slot table, current time, earliest deadline scan and result register
// depends on ttm_pkg and ttm_ram
`timescale 1ns / 1ps
`default_nettype none

module ttm_datapath (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire ttm_pkg::ttm_cmd_type         cmd,
   output ttm_pkg::ttm_stat_type             stat,
   input  wire logic [1:0]                   req_type,
   input  wire logic [ttm_pkg::SLOT_W-1:0]   req_slot_id,
   input  wire logic [ttm_pkg::TIME_W-1:0]   req_time_value,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic                              rsp_fired_valid,
   output logic [ttm_pkg::SLOT_W-1:0]        rsp_fired_slot,
   output logic                              rsp_next_valid,
   output logic [ttm_pkg::TIME_W-1:0]        rsp_next_deadline,
   output logic                              rsp_time_error,
   output logic                              rsp_last
);

   import ttm_pkg::*;

   logic [NUM_SLOTS-1:0]  armed_ff;
   logic [TIME_W-1:0]     cur_time_ff;
   logic                  is_collect_ff;
   logic                  terr_ff;
   logic [FIRE_CNT_W-1:0] fire_cnt_ff;
   logic [SLOT_W-1:0]     fired_slot_ff;

   // scan pipeline
   logic                  iss_on_ff;
   logic [SLOT_W-1:0]     iss_idx_ff;
   logic                  rd_on_ff;
   logic [SLOT_W-1:0]     rd_idx_ff;
   logic                  rd_armed_ff;
   logic                  found_ff;
   logic [SLOT_W-1:0]     best_slot_ff;
   logic [TIME_W-1:0]     best_dl_ff;

   logic                  rsp_valid_ff;
   logic                  out_fired_ff;
   logic [SLOT_W-1:0]     out_slot_ff;
   logic                  out_next_valid_ff;
   logic [TIME_W-1:0]     out_next_dl_ff;
   logic                  out_terr_ff;
   logic                  out_last_ff;

   logic                  slot_ok;
   logic                  ram_wr;
   logic [TIME_W-1:0]     ram_q;
   logic                  take_best;

   assign slot_ok   = {1'b0, req_slot_id} < (SLOT_W + 1)'(NUM_SLOTS);
   assign ram_wr    = cmd.apply && (req_type == REQ_SET) && slot_ok;
   assign take_best = rd_on_ff && rd_armed_ff && (!found_ff || (ram_q < best_dl_ff));

   ttm_ram #(
      .WIDTH (TIME_W),
      .DEPTH (NUM_SLOTS)
   ) u_deadline_ram (
      .clock   (clock),
      .wr_en   (ram_wr),
      .wr_addr (req_slot_id),
      .wr_data (req_time_value),
      .rd_en   (iss_on_ff),
      .rd_addr (iss_idx_ff),
      .rd_data (ram_q)
   );

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff     <= '0;
         cur_time_ff  <= '0;
         iss_on_ff    <= 1'b0;
         rd_on_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.apply && slot_ok && (req_type == REQ_SET)) begin
            armed_ff[req_slot_id] <= 1'b1;
         end else if (cmd.apply && slot_ok && (req_type == REQ_REMOVE)) begin
            armed_ff[req_slot_id] <= 1'b0;
         end else if (cmd.fire) begin
            armed_ff[best_slot_ff] <= 1'b0;
         end
         if (cmd.apply && (req_type == REQ_ADVANCE) && (req_time_value >= cur_time_ff)) begin
            cur_time_ff <= req_time_value;
         end
         if (cmd.scan_start) begin
            iss_on_ff <= 1'b1;
         end else if (iss_on_ff && (iss_idx_ff == SLOT_W'(NUM_SLOTS - 1))) begin
            iss_on_ff <= 1'b0;
         end
         rd_on_ff <= iss_on_ff;
         if (cmd.load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.apply) begin
         is_collect_ff <= (req_type == REQ_COLLECT);
         terr_ff       <= (req_type == REQ_ADVANCE) && (req_time_value < cur_time_ff);
         fire_cnt_ff   <= '0;
      end else if (cmd.fire) begin
         fire_cnt_ff   <= fire_cnt_ff + FIRE_CNT_W'(1);
      end
      if (cmd.fire) begin
         fired_slot_ff <= best_slot_ff;
      end
      if (cmd.scan_start) begin
         iss_idx_ff <= '0;
      end else if (iss_on_ff) begin
         iss_idx_ff <= iss_idx_ff + SLOT_W'(1);
      end
      rd_idx_ff   <= iss_idx_ff;
      rd_armed_ff <= armed_ff[iss_idx_ff];
      if (cmd.scan_start) begin
         found_ff <= 1'b0;
      end else if (take_best) begin
         found_ff     <= 1'b1;
         best_slot_ff <= rd_idx_ff;
         best_dl_ff   <= ram_q;
      end
      if (cmd.load_out) begin
         out_fired_ff      <= cmd.out_fired;
         out_slot_ff       <= cmd.out_fired ? fired_slot_ff : '0;
         out_next_valid_ff <= found_ff;
         out_next_dl_ff    <= found_ff ? best_dl_ff : '0;
         out_terr_ff       <= terr_ff;
         out_last_ff       <= cmd.out_last;
      end
   end

   always_comb begin
      stat.scan_busy  = iss_on_ff || rd_on_ff;
      stat.expired    = found_ff && (best_dl_ff <= cur_time_ff)
                        && (fire_cnt_ff < FIRE_CNT_W'(MAX_FIRE));
      stat.is_collect = is_collect_ff;
      stat.out_free   = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_fired_valid   = out_fired_ff;
   assign rsp_fired_slot    = out_slot_ff;
   assign rsp_next_valid    = out_next_valid_ff;
   assign rsp_next_deadline = out_next_dl_ff;
   assign rsp_time_error    = out_terr_ff;
   assign rsp_last          = out_last_ff;

endmodule

`default_nettype wire
